>>> rtl/elcg_pkg.sv
// Shared constants and codes for the enveloped LCG noise generator.
// Depends on nothing; the other files that use it refer to it by scoped names.
`default_nettype none

package elcg_pkg;

  // Widths of the configuration port and the payload fields.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LEN_W      = 23;
  localparam int STEP_W     = 17;
  localparam int VOL_W      = 8;
  localparam int FACTOR_W   = 32;
  localparam int SAMPLE_W   = 18;
  localparam int PHASE_W    = 17;
  localparam int RNG_W      = 32;

  // Width of the serial multiplier's multiplier operand.
  localparam int MUL_B_W = 32;

  // Default values of the top-level parameters.
  localparam int AMP_FRAC_BITS_DEF = 48;
  localparam int COUNT_BITS_DEF    = 23;

  // Register reset values.
  localparam logic [LEN_W-1:0]    ATTACK_LEN_RST  = 23'd768;
  localparam logic [LEN_W-1:0]    SUSTAIN_LEN_RST = 23'd768;
  localparam logic [LEN_W-1:0]    RELEASE_LEN_RST = 23'd24576;
  localparam logic [STEP_W-1:0]   COLOR_STEP_RST  = 17'd65536;
  localparam logic [VOL_W-1:0]    VOLUME_RST      = 8'd128;
  localparam logic [FACTOR_W-1:0] UNITY_Q30       = 32'h4000_0000;

  // Noise source constants.
  localparam logic [RNG_W-1:0] LCG_MUL  = 32'd1103515245;
  localparam logic [RNG_W-1:0] LCG_INC  = 32'd12345;
  localparam logic [RNG_W-1:0] RNG_SEED = 32'h16BA_2118;
  localparam logic [30:0]      LCG_MID  = 31'h4000_0000;

  // Limits of a noise point.
  localparam logic [SAMPLE_W-1:0] PT_POS_MAX = 18'h1FFFF;
  localparam logic [SAMPLE_W-1:0] PT_MAG_MAX = 18'h20000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_LEN  = 3'd0,
    CFG_SUSTAIN_LEN = 3'd1,
    CFG_RELEASE_LEN = 3'd2,
    CFG_COLOR_STEP  = 3'd3,
    CFG_VOLUME      = 3'd4,
    CFG_ATTACK_FAC  = 3'd5,
    CFG_RELEASE_FAC = 3'd6
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/elcg_in_if.sv
// Input channel of the noise generator: trigger, stop and sample tick.
// Depends on nothing.
`default_nettype none

interface elcg_in_if;
  logic valid;
  logic ready;
  logic trigger;
  logic stop_now;
  logic sample_tick;

  modport source (output valid, output trigger, output stop_now, output sample_tick,
                  input ready);
  modport sink (input valid, input trigger, input stop_now, input sample_tick,
                output ready);
endinterface

`default_nettype wire

>>> rtl/elcg_out_if.sv
// Result channel of the noise generator: one sample and the activity flag.
// Depends on elcg_pkg for the sample width.
`default_nettype none

interface elcg_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [elcg_pkg::SAMPLE_W-1:0]  sample_out;
  logic                                  voice_active;

  modport source (output valid, output sample_out, output voice_active, input ready);
  modport sink (input valid, input sample_out, input voice_active, output ready);
endinterface

`default_nettype wire

>>> rtl/elcg_cfg_if.sv
// Configuration write channel of the noise generator.
// Depends on elcg_pkg for the index and data widths.
`default_nettype none

interface elcg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [elcg_pkg::CFG_IDX_W-1:0]    index;
  logic [elcg_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/elcg_serial_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing; used by the noise generator top level.
`default_nettype none

module elcg_serial_mul #(
  parameter int AW = 40,
  parameter int BW = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic                  done,
  output logic [AW+BW-1:0]      p
);

  localparam int CNT_W = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_r;
  logic [AW-1:0]    a_r;
  logic [BW-1:0]    b_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [AW:0]      sum;

  // The upper part of the accumulator takes the partial product; the whole
  // accumulator then shifts right one place.
  assign sum = {1'b0, acc_r[AW+BW-1:BW]} + (b_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      acc_r  <= '0;
      a_r    <= '0;
      b_r    <= '0;
    end else begin
      // Done pulses for one cycle after the last shift.
      done_r <= busy_r && !start && (cnt_r == CNT_W'(1));
      if (start) begin
        acc_r  <= '0;
        a_r    <= a;
        b_r    <= b;
        cnt_r  <= CNT_W'(BW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= {sum, acc_r[BW-1:1]};
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

`default_nettype wire

>>> rtl/enveloped_lcg_noise_generator.sv
// Top level of the enveloped LCG noise voice: envelope, noise points and
// interpolation sequenced around one shared serial multiplier.
// Depends on elcg_pkg, the three channel interfaces and elcg_serial_mul.
//
// Usage: each input transaction carries a trigger, a stop and a sample tick.
// Trigger and stop take effect in the cycle the transaction is accepted.
// A transaction without a sample tick returns no result and leaves the input
// open in the next cycle. A tick while the voice is idle passes through the
// output step and presents a zero sample once the output register is free.
// A tick on an active voice runs a chain of multiplications through the
// bit-serial multiplier (one multiplier bit per cycle), each made of a start,
// a load of the operands and one shift per multiplier bit: interpolation and
// amplitude update always, plus the LCG step and the point scaling when the
// phase wraps and a new noise point is drawn. Items are processed one at a
// time.
// The result sits in an output register; the input is accepted again in the
// cycle after that register is loaded. While the receiver stalls with a
// result still held, the next result waits in its final state and the input
// stays closed. Configuration writes are always accepted and should be done
// while the voice has no transaction in flight.
// Reset (rst_n low, synchronous) restores register defaults, puts the envelope
// in idle, clears points and phase and reseeds the LCG.
`default_nettype none

module enveloped_lcg_noise_generator #(
  parameter int AMP_FRAC_BITS = elcg_pkg::AMP_FRAC_BITS_DEF,
  parameter int COUNT_BITS    = elcg_pkg::COUNT_BITS_DEF
) (
  input wire logic     clk,
  input wire logic     rst_n,
  elcg_in_if.sink      in_ch,
  elcg_out_if.source   out_ch,
  elcg_cfg_if.sink     cfg_ch
);

  // Amplitude width; it saturates at all ones.
  localparam int AMPW = AMP_FRAC_BITS - 8;
  localparam int MBW  = elcg_pkg::MUL_B_W;
  localparam int PW   = AMPW + MBW;
  localparam int QW   = PW - AMP_FRAC_BITS;
  localparam logic [AMPW-1:0] AMP_MIN =
      AMPW'(((64'd1 << (AMP_FRAC_BITS - 16)) + 64'd5000) / 64'd10000);
  localparam logic [AMPW-1:0] AMP_MAX = '1;

  typedef enum logic [1:0] {
    ENV_ATTACK  = 2'd0,
    ENV_SUSTAIN = 2'd1,
    ENV_RELEASE = 2'd2,
    ENV_IDLE    = 2'd3
  } env_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_INTERP, SQ_AMP, SQ_LCG, SQ_POINT, SQ_FINISH, SQ_OUT
  } seq_t;

  // Configuration registers.
  logic [elcg_pkg::LEN_W-1:0]    attack_len_r, sustain_len_r, release_len_r;
  logic [elcg_pkg::STEP_W-1:0]   color_step_r;
  logic [elcg_pkg::VOL_W-1:0]    volume_r;
  logic [elcg_pkg::FACTOR_W-1:0] attack_fac_r, release_fac_r;

  // Voice state.
  seq_t                           seq_r;
  env_t                           stage_r;
  logic [COUNT_BITS-1:0]          cnt_r;
  logic [AMPW-1:0]                amp_r;
  logic [elcg_pkg::FACTOR_W-1:0]  mult_r;
  logic [elcg_pkg::SAMPLE_W-1:0]  prev_r, next_r;
  logic [elcg_pkg::PHASE_W-1:0]   phase_r;
  logic [elcg_pkg::RNG_W-1:0]     rng_r;
  logic                           pt_neg_r;
  logic [elcg_pkg::SAMPLE_W-1:0]  val_r;
  logic                           act_r;

  // Output register.
  logic                           out_valid_r;
  logic [elcg_pkg::SAMPLE_W-1:0]  out_sample_r;
  logic                           out_active_r;

  // Multiplier request.
  logic                           mul_start_r;
  logic [AMPW-1:0]                mul_a_r;
  logic [MBW-1:0]                 mul_b_r;
  logic                           mul_done;
  logic [PW-1:0]                  mul_p;

  elcg_serial_mul #(
    .AW (AMPW),
    .BW (MBW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  logic in_acc;
  logic out_free;
  assign in_ch.ready  = (seq_r == SQ_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Difference between points, as sign and magnitude for the unsigned multiplier.
  logic [elcg_pkg::SAMPLE_W:0] diff, diff_mag;
  logic                        diff_neg;
  assign diff     = {next_r[elcg_pkg::SAMPLE_W-1], next_r} -
                    {prev_r[elcg_pkg::SAMPLE_W-1], prev_r};
  assign diff_neg = diff[elcg_pkg::SAMPLE_W];
  assign diff_mag = diff_neg ? -diff : diff;

  // Interpolation: prev + floor(diff * phase / 65536).
  logic [35:0]                   interp_t;
  logic [elcg_pkg::SAMPLE_W-1:0] interp_val;
  assign interp_t   = diff_neg ? -{1'b0, mul_p[34:0]} : {1'b0, mul_p[34:0]};
  assign interp_val = prev_r + interp_t[33:16];

  // Amplitude update: floor(amp * factor / 2^30), saturated.
  logic [AMPW+1:0] amp_q;
  logic [AMPW-1:0] amp_new;
  assign amp_q   = mul_p[AMPW+31:30];
  assign amp_new = (amp_q[AMPW+1:AMPW] != 2'b00) ? AMP_MAX : amp_q[AMPW-1:0];

  // Phase advance.
  logic [elcg_pkg::PHASE_W-1:0] phase_sum;
  assign phase_sum = phase_r + color_step_r;

  // LCG step, centered on zero.
  logic [elcg_pkg::RNG_W-1:0] lcg_new;
  logic [30:0]                low31, lcg_mag;
  logic                       lcg_neg;
  assign lcg_new = mul_p[elcg_pkg::RNG_W-1:0] + elcg_pkg::LCG_INC;
  assign low31   = lcg_new[30:0];
  assign lcg_neg = !low31[30];
  assign lcg_mag = lcg_neg ? (elcg_pkg::LCG_MID - low31) : (low31 - elcg_pkg::LCG_MID);

  // Noise point: amp * mag / 2^AMP_FRAC_BITS, saturated to 18-bit signed.
  logic [QW-1:0]                 pt_q;
  logic [elcg_pkg::SAMPLE_W-1:0] pt_mag, pt_val;
  assign pt_q   = mul_p[PW-1:AMP_FRAC_BITS];
  assign pt_mag = (pt_q > QW'(elcg_pkg::PT_MAG_MAX)) ? elcg_pkg::PT_MAG_MAX
                                                      : pt_q[elcg_pkg::SAMPLE_W-1:0];
  assign pt_val = pt_neg_r ? -pt_mag
                : ((pt_mag == elcg_pkg::PT_MAG_MAX) ? elcg_pkg::PT_POS_MAX : pt_mag);

  // Envelope after the trigger and stop of the item being accepted.
  logic trig_go;
  env_t ev_stage;
  assign trig_go  = in_ch.trigger && (volume_r != '0);
  assign ev_stage = in_ch.stop_now ? ENV_IDLE : (trig_go ? ENV_ATTACK : stage_r);

  // A multiplication starts whenever the sequence moves on to a step that needs one.
  logic mul_go;
  always_comb begin
    case (seq_r)
      SQ_IDLE:   mul_go = in_acc && in_ch.sample_tick && (ev_stage != ENV_IDLE);
      SQ_INTERP: mul_go = mul_done;
      SQ_AMP:    mul_go = mul_done && phase_sum[elcg_pkg::PHASE_W-1];
      SQ_LCG:    mul_go = mul_done;
      default:   mul_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_len_r  <= elcg_pkg::ATTACK_LEN_RST;
      sustain_len_r <= elcg_pkg::SUSTAIN_LEN_RST;
      release_len_r <= elcg_pkg::RELEASE_LEN_RST;
      color_step_r  <= elcg_pkg::COLOR_STEP_RST;
      volume_r      <= elcg_pkg::VOLUME_RST;
      attack_fac_r  <= elcg_pkg::UNITY_Q30;
      release_fac_r <= elcg_pkg::UNITY_Q30;
      seq_r         <= SQ_IDLE;
      stage_r       <= ENV_IDLE;
      cnt_r         <= '0;
      amp_r         <= '0;
      mult_r        <= '0;
      prev_r        <= '0;
      next_r        <= '0;
      phase_r       <= '0;
      rng_r         <= elcg_pkg::RNG_SEED;
      pt_neg_r      <= 1'b0;
      val_r         <= '0;
      act_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      out_sample_r  <= '0;
      out_active_r  <= 1'b0;
      mul_start_r   <= 1'b0;
      mul_a_r       <= '0;
      mul_b_r       <= '0;
    end else begin
      mul_start_r <= mul_go;

      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          elcg_pkg::CFG_ATTACK_LEN:  attack_len_r  <= cfg_ch.data[elcg_pkg::LEN_W-1:0];
          elcg_pkg::CFG_SUSTAIN_LEN: sustain_len_r <= cfg_ch.data[elcg_pkg::LEN_W-1:0];
          elcg_pkg::CFG_RELEASE_LEN: release_len_r <= cfg_ch.data[elcg_pkg::LEN_W-1:0];
          elcg_pkg::CFG_COLOR_STEP:  color_step_r  <= cfg_ch.data[elcg_pkg::STEP_W-1:0];
          elcg_pkg::CFG_VOLUME:      volume_r      <= cfg_ch.data[elcg_pkg::VOL_W-1:0];
          elcg_pkg::CFG_ATTACK_FAC:  attack_fac_r  <= cfg_ch.data[elcg_pkg::FACTOR_W-1:0];
          elcg_pkg::CFG_RELEASE_FAC: release_fac_r <= cfg_ch.data[elcg_pkg::FACTOR_W-1:0];
          default: ;
        endcase
      end

      // The output register is loaded from the last step and held until taken.
      out_valid_r <= ((seq_r == SQ_OUT) && out_free) || (out_valid_r && !out_ch.ready);

      case (seq_r)
        SQ_IDLE: begin
          if (in_acc) begin
            stage_r <= ev_stage;
            if (trig_go) begin
              cnt_r  <= COUNT_BITS'(attack_len_r);
              amp_r  <= AMP_MIN;
              mult_r <= attack_fac_r;
            end
            if (in_ch.sample_tick) begin
              if (ev_stage != ENV_IDLE) begin
                act_r   <= 1'b1;
                mul_a_r <= AMPW'(diff_mag);
                mul_b_r <= MBW'(phase_r);
                seq_r   <= SQ_INTERP;
              end else begin
                act_r <= 1'b0;
                val_r <= '0;
                seq_r <= SQ_OUT;
              end
            end
          end
        end
        SQ_INTERP: begin
          if (mul_done) begin
            val_r   <= interp_val;
            mul_a_r <= amp_r;
            mul_b_r <= mult_r;
            seq_r   <= SQ_AMP;
          end
        end
        SQ_AMP: begin
          if (mul_done) begin
            amp_r   <= amp_new;
            phase_r <= phase_sum;
            if (phase_sum[elcg_pkg::PHASE_W-1]) begin
              // A new noise point is due.
              prev_r  <= next_r;
              mul_a_r <= AMPW'(rng_r);
              mul_b_r <= elcg_pkg::LCG_MUL;
              seq_r   <= SQ_LCG;
            end else begin
              seq_r <= SQ_FINISH;
            end
          end
        end
        SQ_LCG: begin
          if (mul_done) begin
            rng_r    <= {1'b0, low31} - {1'b0, elcg_pkg::LCG_MID};
            pt_neg_r <= lcg_neg;
            mul_a_r  <= amp_r;
            mul_b_r  <= MBW'(lcg_mag);
            seq_r    <= SQ_POINT;
          end
        end
        SQ_POINT: begin
          if (mul_done) begin
            next_r  <= pt_val;
            phase_r <= {1'b0, phase_r[elcg_pkg::PHASE_W-2:0]};
            seq_r   <= SQ_FINISH;
          end
        end
        SQ_FINISH: begin
          // Stage countdown; a zero length behaves as one sample.
          if (cnt_r > COUNT_BITS'(1)) begin
            cnt_r <= cnt_r - 1'b1;
          end else begin
            case (stage_r)
              ENV_ATTACK: begin
                stage_r <= ENV_SUSTAIN;
                cnt_r   <= COUNT_BITS'(sustain_len_r);
                mult_r  <= elcg_pkg::UNITY_Q30;
              end
              ENV_SUSTAIN: begin
                stage_r <= ENV_RELEASE;
                cnt_r   <= COUNT_BITS'(release_len_r);
                mult_r  <= release_fac_r;
              end
              default: begin
                stage_r <= ENV_IDLE;
                cnt_r   <= '0;
              end
            endcase
          end
          seq_r <= SQ_OUT;
        end
        SQ_OUT: begin
          if (out_free) begin
            out_sample_r <= val_r;
            out_active_r <= act_r;
            seq_r        <= SQ_IDLE;
          end
        end
        default: seq_r <= SQ_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_out   = $signed(out_sample_r);
  assign out_ch.voice_active = out_active_r;

endmodule

`default_nettype wire
